// ----- hdl/gd3_pkg.sv -----
// shared constants, types and helpers of the 3x3 grayscale dilation core
`default_nettype none

package gd3_pkg;

  localparam int MAX_WIDTH    = 64;
  localparam int HEIGHT_LIMIT = 64;

  localparam int PIX_W  = 8;
  localparam int IMG_W  = 7;
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(HEIGHT_LIMIT);
  localparam int CFG_AW = 1;

  localparam int OUT_DEPTH = 4;
  localparam int OPTR_W    = $clog2(OUT_DEPTH);
  localparam int OCNT_W    = $clog2(OUT_DEPTH + 1);

  localparam logic [CFG_AW-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_AW-1:0] REG_IMAGE_HEIGHT = 1'b1;

  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_DRAIN = 1'b1;

  // one column of the line store: max of the last two rows and the last row
  typedef struct packed {
    logic [PIX_W-1:0] m;
    logic [PIX_W-1:0] p;
  } gd3_word_t;

  // request handed from the sequencer to the window stage
  typedef struct packed {
    logic             act;
    logic             drain;
    logic             emit;
    logic             row0;
    logic             left_ok;
    logic             right_ok;
    logic             c_mem;
    logic             last;
    logic [PIX_W-1:0] pixel;
    logic [COL_W-1:0] addr_a;
    logic [COL_W-1:0] addr_b;
  } gd3_issue_t;

  function automatic logic [PIX_W-1:0] max8(input logic [PIX_W-1:0] a,
                                            input logic [PIX_W-1:0] b);
    max8 = (a > b) ? a : b;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/gd3_line_mem.sv -----
// column store: one write port, two registered read ports
`default_nettype none

module gd3_line_mem
  import gd3_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [COL_W-1:0] waddr_i,
  input  gd3_word_t             wdata_i,
  input  wire logic             re_i,
  input  wire logic [COL_W-1:0] raddr_a_i,
  input  wire logic [COL_W-1:0] raddr_b_i,
  output gd3_word_t             rdata_a_o,
  output gd3_word_t             rdata_b_o
);

  gd3_word_t mem [MAX_WIDTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_o <= mem[raddr_a_i];
      rdata_b_o <= mem[raddr_b_i];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/gd3_ctrl.sv -----
// frame sequencer: config registers, positions, pending count and request issue
`default_nettype none

module gd3_ctrl
  import gd3_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [CFG_AW-1:0] cfg_addr_i,
  input  wire logic [IMG_W-1:0]  cfg_wdata_i,
  input  wire logic              s_valid_i,
  input  wire logic              s_kind_i,
  input  wire logic [PIX_W-1:0]  s_pixel_i,
  output logic                   s_ready_o,
  input  wire logic [OCNT_W-1:0] fifo_cnt_i,
  input  wire logic              res_pend_i,
  output gd3_issue_t             issue_o
);

  logic [IMG_W-1:0] width_q, width_d;
  logic [IMG_W-1:0] height_q, height_d;
  logic [COL_W-1:0] in_col_q, in_col_d;
  logic [ROW_W-1:0] in_row_q, in_row_d;
  logic [COL_W-1:0] out_col_q, out_col_d;
  logic [ROW_W-1:0] out_row_q, out_row_d;
  logic [IMG_W-1:0] pending_q, pending_d;
  logic             full_q, full_d;

  logic [IMG_W-1:0] width_m1_full, height_m1_full;
  logic [COL_W-1:0] width_m1;
  logic [ROW_W-1:0] height_m1;
  logic [IMG_W-1:0] cfg_val;
  logic [OCNT_W-1:0] credit;
  logic             accept, pix_act, drain_act, emit;
  logic             in_col_end, in_row_end, out_col_end, out_row_end;

  assign width_m1_full  = width_q - IMG_W'(1);
  assign height_m1_full = height_q - IMG_W'(1);
  assign width_m1       = width_m1_full[COL_W-1:0];
  assign height_m1      = height_m1_full[ROW_W-1:0];

  // room for everything already in flight plus this request
  assign credit    = fifo_cnt_i + OCNT_W'(res_pend_i);
  assign s_ready_o = (credit < OCNT_W'(OUT_DEPTH));
  assign accept    = s_valid_i & s_ready_o;

  assign in_col_end  = (in_col_q == width_m1);
  assign in_row_end  = (in_row_q == height_m1);
  assign out_col_end = (out_col_q == width_m1);
  assign out_row_end = (out_row_q == height_m1);

  assign drain_act = accept & (s_kind_i == REQ_DRAIN) & full_q & (pending_q != '0);
  assign pix_act   = accept & (s_kind_i == REQ_PIXEL) & ~full_q;
  assign emit      = drain_act | (pix_act & (pending_q > width_q));

  assign cfg_val = (cfg_wdata_i == '0) ? IMG_W'(1) : cfg_wdata_i;

  always_comb begin
    width_d   = width_q;
    height_d  = height_q;
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    pending_d = pending_q;
    full_d    = full_q;
    if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_IMAGE_WIDTH: begin
          width_d = (cfg_val > IMG_W'(MAX_WIDTH)) ? IMG_W'(MAX_WIDTH) : cfg_val;
        end
        REG_IMAGE_HEIGHT: begin
          height_d = (cfg_val > IMG_W'(HEIGHT_LIMIT)) ? IMG_W'(HEIGHT_LIMIT) : cfg_val;
        end
      endcase
      in_col_d  = '0;
      in_row_d  = '0;
      out_col_d = '0;
      out_row_d = '0;
      pending_d = '0;
      full_d    = 1'b0;
    end else begin
      if (pix_act) begin
        if (in_col_end) begin
          in_col_d = '0;
          in_row_d = in_row_end ? '0 : in_row_q + ROW_W'(1);
          if (in_row_end) begin
            full_d = 1'b1;
          end
        end else begin
          in_col_d = in_col_q + COL_W'(1);
        end
      end
      if (emit) begin
        if (out_col_end) begin
          out_col_d = '0;
          out_row_d = out_row_end ? '0 : out_row_q + ROW_W'(1);
          // last output of the frame closes it
          if (out_row_end) begin
            full_d = 1'b0;
          end
        end else begin
          out_col_d = out_col_q + COL_W'(1);
        end
      end
      if (pix_act && !emit) begin
        pending_d = pending_q + IMG_W'(1);
      end else if (drain_act) begin
        pending_d = pending_q - IMG_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= IMG_W'(MAX_WIDTH);
      height_q  <= IMG_W'(HEIGHT_LIMIT);
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      pending_q <= '0;
      full_q    <= 1'b0;
    end else begin
      width_q   <= width_d;
      height_q  <= height_d;
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
      pending_q <= pending_d;
      full_q    <= full_d;
    end
  end

  // pixels read/write their own column, drains read the next and current column
  always_comb begin
    issue_o.act      = pix_act | drain_act;
    issue_o.drain    = drain_act;
    issue_o.emit     = emit;
    issue_o.row0     = (in_row_q == '0);
    issue_o.left_ok  = (out_col_q != '0);
    issue_o.right_ok = ~out_col_end;
    issue_o.c_mem    = drain_act & out_row_end;
    issue_o.last     = out_col_end & out_row_end;
    issue_o.pixel    = s_pixel_i;
    issue_o.addr_a   = drain_act ? out_col_q + COL_W'(1) : in_col_q;
    issue_o.addr_b   = out_col_q;
  end

  a_full_has_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(full_q && pending_q == '0))
    else $error("frame marked received with nothing pending");

  a_pending_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, pending_q} <= {1'b0, width_q} + (IMG_W + 1)'(1))
    else $error("pending count beyond one row and one pixel");

  a_out_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_col_q <= width_m1) && (out_row_q <= height_m1) && (in_col_q <= width_m1))
    else $error("position outside the configured frame");

endmodule

`default_nettype wire

// ----- hdl/gd3_window.sv -----
// window stage: column max update with forwarding, horizontal 3-tap max
`default_nettype none

module gd3_window
  import gd3_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  gd3_issue_t             issue_i,
  input  gd3_word_t              rdata_a_i,
  input  gd3_word_t              rdata_b_i,
  output logic                   we_o,
  output logic [COL_W-1:0]       waddr_o,
  output gd3_word_t              wdata_o,
  output logic                   res_valid_o,
  output logic [PIX_W-1:0]       res_pixel_o,
  output logic                   res_last_o
);

  gd3_issue_t       iss_q;
  logic             iss_v_q;
  logic [PIX_W-1:0] s1_q, s2_q;
  logic             fwd_v_q;
  logic [COL_W-1:0] fwd_addr_q;
  gd3_word_t        fwd_data_q;

  gd3_word_t        word_a, word_b;
  logic [PIX_W-1:0] col_new, m_new, r_used, c_used, l_val, r_val;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iss_v_q <= 1'b0;
      fwd_v_q <= 1'b0;
    end else begin
      iss_v_q <= issue_i.act;
      fwd_v_q <= we_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue_i.act) begin
      iss_q <= issue_i;
    end
    fwd_addr_q <= waddr_o;
    fwd_data_q <= wdata_o;
    if (iss_v_q) begin
      s2_q <= c_used;
      s1_q <= r_used;
    end
  end

  // the write of the previous cycle is not yet visible in the read data
  assign word_a = (fwd_v_q && fwd_addr_q == iss_q.addr_a) ? fwd_data_q : rdata_a_i;
  assign word_b = (fwd_v_q && fwd_addr_q == iss_q.addr_b) ? fwd_data_q : rdata_b_i;

  assign col_new = max8(word_a.m, iss_q.pixel);
  assign m_new   = iss_q.row0 ? iss_q.pixel : max8(word_a.p, iss_q.pixel);

  assign r_used = iss_q.drain ? word_a.m : col_new;
  assign c_used = iss_q.c_mem ? word_b.m : s1_q;
  assign l_val  = iss_q.left_ok ? s2_q : '0;
  assign r_val  = iss_q.right_ok ? r_used : '0;

  assign we_o      = iss_v_q & ~iss_q.drain;
  assign waddr_o   = iss_q.addr_a;
  assign wdata_o.m = m_new;
  assign wdata_o.p = iss_q.pixel;

  assign res_valid_o = iss_v_q & iss_q.emit;
  assign res_pixel_o = max8(max8(l_val, c_used), r_val);
  assign res_last_o  = iss_q.last;

endmodule

`default_nettype wire

// ----- hdl/gd3_out_fifo.sv -----
// small result queue in front of the output channel
`default_nettype none

module gd3_out_fifo
  import gd3_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire logic [PIX_W-1:0]  push_pixel_i,
  input  wire logic              push_last_i,
  output logic                   valid_o,
  input  wire logic              ready_i,
  output logic [PIX_W-1:0]       pixel_o,
  output logic                   last_o,
  output logic [OCNT_W-1:0]      cnt_o
);

  logic [PIX_W:0]    buf_q [OUT_DEPTH];
  logic [OPTR_W-1:0] wr_q, rd_q;
  logic [OCNT_W-1:0] cnt_q, cnt_d;
  logic              pop;

  assign valid_o = (cnt_q != '0);
  assign pop     = valid_o & ready_i;
  assign pixel_o = buf_q[rd_q][PIX_W-1:0];
  assign last_o  = buf_q[rd_q][PIX_W];
  assign cnt_o   = cnt_q;

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop) begin
      cnt_d = cnt_q + OCNT_W'(1);
    end else if (!push_i && pop) begin
      cnt_d = cnt_q - OCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_q <= wr_q + OPTR_W'(1);
      end
      if (pop) begin
        rd_q <= rd_q + OPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_q] <= {push_last_i, push_pixel_i};
    end
  end

endmodule

`default_nettype wire

// ----- hdl/grayscale_dilate_3x3_core.sv -----
// top level of the streaming 3x3 grayscale dilation (max filter)
//
// usage:
//   s_axis carries one request per beat: tuser selects a pixel (0) or a
//   drain step (1), tdata[7:0] is the pixel in raster order. m_axis returns
//   the 3x3 neighborhood maximum in tdata[7:0], tlast marks the last pixel
//   of the frame. Output n leaves once pixel n+width+1 is in; after the last
//   pixel of the frame, drain requests flush the rest one per request.
//   cfg_we_i/cfg_addr_i/cfg_wdata_i set width (0) and height (1), 1..64, and
//   restart the frame; write only while the core is idle.
// timing:
//   a request is taken every cycle while tready is high. The column store
//   is one 64 x 16 memory with registered reads, read and written back
//   once per pixel, forwarded across adjacent pixels.
// reset and stall:
//   reset sets a 64 x 64 frame and clears all positions; the store needs no
//   clearing. A 4-entry result queue absorbs a stalled receiver; tready drops
//   only when the queue cannot take every result still in flight.
`default_nettype none

module grayscale_dilate_3x3_core
  import gd3_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [CFG_AW-1:0] cfg_addr_i,
  input  wire logic [IMG_W-1:0]  cfg_wdata_i,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [7:0]        s_axis_tdata,   // [7:0] pixel_in
  input  wire logic              s_axis_tuser,   // [0] req_type
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic [7:0]             m_axis_tdata,   // [7:0] pixel_out
  output logic                   m_axis_tlast
);

  gd3_issue_t        issue;
  gd3_word_t         rdata_a, rdata_b, wdata;
  logic              we;
  logic [COL_W-1:0]  waddr;
  logic              res_valid, res_last;
  logic [PIX_W-1:0]  res_pixel;
  logic [OCNT_W-1:0] fifo_cnt;

  gd3_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_valid_i   (s_axis_tvalid),
    .s_kind_i    (s_axis_tuser),
    .s_pixel_i   (s_axis_tdata),
    .s_ready_o   (s_axis_tready),
    .fifo_cnt_i  (fifo_cnt),
    .res_pend_i  (res_valid),
    .issue_o     (issue)
  );

  gd3_line_mem u_mem (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .re_i      (issue.act),
    .raddr_a_i (issue.addr_a),
    .raddr_b_i (issue.addr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  gd3_window u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .issue_i     (issue),
    .rdata_a_i   (rdata_a),
    .rdata_b_i   (rdata_b),
    .we_o        (we),
    .waddr_o     (waddr),
    .wdata_o     (wdata),
    .res_valid_o (res_valid),
    .res_pixel_o (res_pixel),
    .res_last_o  (res_last)
  );

  gd3_out_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (res_valid),
    .push_pixel_i (res_pixel),
    .push_last_i  (res_last),
    .valid_o      (m_axis_tvalid),
    .ready_i      (m_axis_tready),
    .pixel_o      (m_axis_tdata),
    .last_o       (m_axis_tlast),
    .cnt_o        (fifo_cnt)
  );

endmodule

`default_nettype wire

// ----- verif/grayscale_dilate_3x3_core_test.sv -----
// testbench of the streaming 3x3 grayscale dilation core: directed table, then random frames
`timescale 1ns / 100ps

module grayscale_dilate_3x3_core_test;
  import gd3_pkg::*;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             last;
  } dil_result_t;

  typedef enum logic {ROW_CFG, ROW_REQ} tab_kind_e;

  // sel is the register index of a write or the request type of a request
  typedef struct packed {
    tab_kind_e        kind;
    logic             sel;
    logic [7:0]       val;
    logic             typed;
    logic             has;
    logic [PIX_W-1:0] epix;
    logic             elast;
  } tab_row_t;

  localparam tab_row_t DIR_TAB [31] = '{
    // default 64 x 64 frame: drain before the frame is in does nothing
    '{ROW_REQ, REQ_DRAIN, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0},
    '{ROW_REQ, REQ_PIXEL, 8'hff, 1'b1, 1'b0, 8'h00, 1'b0},
    '{ROW_REQ, REQ_DRAIN, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0},
    // 1 x 1 frame, write aborts the partial frame above
    '{ROW_CFG, REG_IMAGE_WIDTH, 8'd1, 1'b0, 1'b0, 8'h00, 1'b0},
    '{ROW_CFG, REG_IMAGE_HEIGHT, 8'd1, 1'b0, 1'b0, 8'h00, 1'b0},
    '{ROW_REQ, REQ_PIXEL, 8'hff, 1'b1, 1'b0, 8'h00, 1'b0},
    // pixel after a complete frame is dropped
    '{ROW_REQ, REQ_PIXEL, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0},
    '{ROW_REQ, REQ_DRAIN, 8'h00, 1'b1, 1'b1, 8'hff, 1'b1},
    '{ROW_REQ, REQ_DRAIN, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0},
    // zero sizes are taken as one
    '{ROW_CFG, REG_IMAGE_WIDTH, 8'd0, 1'b0, 1'b0, 8'h00, 1'b0},
    '{ROW_CFG, REG_IMAGE_HEIGHT, 8'd0, 1'b0, 1'b0, 8'h00, 1'b0},
    '{ROW_REQ, REQ_PIXEL, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0},
    '{ROW_REQ, REQ_DRAIN, 8'hff, 1'b1, 1'b1, 8'h00, 1'b1},
    // oversize values clamp to 64 x 64
    '{ROW_CFG, REG_IMAGE_WIDTH, 8'd127, 1'b0, 1'b0, 8'h00, 1'b0},
    '{ROW_CFG, REG_IMAGE_HEIGHT, 8'd127, 1'b0, 1'b0, 8'h00, 1'b0},
    '{ROW_REQ, REQ_PIXEL, 8'h80, 1'b1, 1'b0, 8'h00, 1'b0},
    '{ROW_REQ, REQ_PIXEL, 8'h7f, 1'b1, 1'b0, 8'h00, 1'b0},
    // small 3 x 2 frame through the predictor
    '{ROW_CFG, REG_IMAGE_WIDTH, 8'd3, 1'b0, 1'b0, 8'h00, 1'b0},
    '{ROW_CFG, REG_IMAGE_HEIGHT, 8'd2, 1'b0, 1'b0, 8'h00, 1'b0},
    '{ROW_REQ, REQ_PIXEL, 8'h01, 1'b0, 1'b0, 8'h00, 1'b0},
    '{ROW_REQ, REQ_PIXEL, 8'h80, 1'b0, 1'b0, 8'h00, 1'b0},
    '{ROW_REQ, REQ_PIXEL, 8'h02, 1'b0, 1'b0, 8'h00, 1'b0},
    '{ROW_REQ, REQ_PIXEL, 8'h40, 1'b0, 1'b0, 8'h00, 1'b0},
    '{ROW_REQ, REQ_PIXEL, 8'h10, 1'b0, 1'b0, 8'h00, 1'b0},
    '{ROW_REQ, REQ_PIXEL, 8'hfe, 1'b0, 1'b0, 8'h00, 1'b0},
    '{ROW_REQ, REQ_PIXEL, 8'h55, 1'b0, 1'b0, 8'h00, 1'b0},
    '{ROW_REQ, REQ_DRAIN, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
    '{ROW_REQ, REQ_DRAIN, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
    '{ROW_REQ, REQ_DRAIN, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
    '{ROW_REQ, REQ_DRAIN, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
    '{ROW_REQ, REQ_DRAIN, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0}
  };

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [CFG_AW-1:0] cfg_addr_i = '0;
  logic [IMG_W-1:0]  cfg_wdata_i = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [7:0]        s_axis_tdata = '0;
  logic              s_axis_tuser = 1'b0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [7:0]        m_axis_tdata;
  logic              m_axis_tlast;

  // no idling on either side while set
  bit quiet = 1'b0;
  int err_cnt = 0;

  dil_result_t dilated_q [$];

  // predictor state
  logic [PIX_W-1:0] line_mem [3*MAX_WIDTH];
  logic [IMG_W-1:0] dil_w = IMG_W'(MAX_WIDTH);
  logic [IMG_W-1:0] dil_h = IMG_W'(HEIGHT_LIMIT);
  logic [COL_W-1:0] in_col = '0;
  logic [COL_W-1:0] out_col = '0;
  logic [ROW_W-1:0] in_row = '0;
  logic [ROW_W-1:0] out_row = '0;
  logic [12:0]      dil_pend = '0;

  grayscale_dilate_3x3_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic bit frame_full();
    return int'(out_row) * int'(dil_w) + int'(out_col) + int'(dil_pend)
           >= int'(dil_w) * int'(dil_h);
  endfunction

  task automatic step_pos(inout logic [COL_W-1:0] c, inout logic [ROW_W-1:0] r);
    if (int'(c) + 1 >= int'(dil_w)) begin
      c = '0;
      if (int'(r) + 1 >= int'(dil_h)) r = '0;
      else r = r + 1'b1;
    end else begin
      c = c + 1'b1;
    end
  endtask

  // max over the in-bounds window, the pixel at the input position taken from nv
  function automatic logic [PIX_W-1:0] window_peak(input int r, input int c,
                                                   input bit with_new,
                                                   input logic [PIX_W-1:0] nv);
    logic [PIX_W-1:0] best;
    logic [PIX_W-1:0] v;
    int y;
    int x;
    best = '0;
    for (int dy = -1; dy <= 1; dy++) begin
      for (int dx = -1; dx <= 1; dx++) begin
        y = r + dy;
        x = c + dx;
        if (y >= 0 && x >= 0 && y < int'(dil_h) && x < int'(dil_w)) begin
          if (with_new && y == int'(in_row) && x == int'(in_col)) v = nv;
          else v = line_mem[(y % 3) * MAX_WIDTH + x];
          if (v > best) best = v;
        end
      end
    end
    return best;
  endfunction

  task automatic emit_out(input bit with_new, input logic [PIX_W-1:0] nv,
                          output dil_result_t res);
    int idx;
    idx = int'(out_row) * int'(dil_w) + int'(out_col);
    res.pixel = window_peak(int'(out_row), int'(out_col), with_new, nv);
    res.last  = (idx + 1 == int'(dil_w) * int'(dil_h));
    step_pos(out_col, out_row);
  endtask

  task automatic dilate_step(input logic req, input logic [PIX_W-1:0] pix,
                             output bit got, output dil_result_t res);
    got = 1'b0;
    res = '0;
    if (req == REQ_DRAIN) begin
      if (dil_pend != 0 && frame_full()) begin
        emit_out(1'b0, '0, res);
        got = 1'b1;
        dil_pend = dil_pend - 1'b1;
      end
    end else if (!frame_full()) begin
      if (int'(dil_pend) + 1 >= int'(dil_w) + 2) begin
        emit_out(1'b1, pix, res);
        got = 1'b1;
      end
      line_mem[(int'(in_row) % 3) * MAX_WIDTH + int'(in_col)] = pix;
      step_pos(in_col, in_row);
      dil_pend = dil_pend + 13'd1 - 13'(got);
    end
  endtask

  task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [IMG_W-1:0] val);
    logic [IMG_W-1:0] v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    v = (val == 0) ? IMG_W'(1) : val;
    if (idx == REG_IMAGE_WIDTH) dil_w = (v > MAX_WIDTH) ? IMG_W'(MAX_WIDTH) : v;
    else dil_h = (v > HEIGHT_LIMIT) ? IMG_W'(HEIGHT_LIMIT) : v;
    in_col   = '0;
    in_row   = '0;
    out_col  = '0;
    out_row  = '0;
    dil_pend = '0;
  endtask

  // hold requests until every expected pixel is back and the pipeline is empty
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (dilated_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic send_req(input logic req, input logic [7:0] pix, input bit typed,
                          input bit typed_has, input dil_result_t typed_res);
    bit got;
    dil_result_t res;
    @(negedge clk_i);
    while (!quiet && $urandom_range(99) < 24) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= pix;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    dilate_step(req, pix, got, res);
    if (typed) begin
      if (typed_has) dilated_q.push_back(typed_res);
    end else if (got) begin
      dilated_q.push_back(res);
    end
  endtask

  always @(negedge clk_i) begin
    m_axis_tready <= quiet || ($urandom_range(99) >= 24);
  end

  always @(posedge clk_i) begin : result_check
    dil_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (dilated_q.size() == 0) begin
        $error("unexpected result: pixel_out %0d, is_last %0d", m_axis_tdata, m_axis_tlast);
        err_cnt++;
      end else begin
        want = dilated_q.pop_front();
        if (m_axis_tdata != want.pixel) begin
          $error("pixel_out mismatch: expected %0d, actual %0d", want.pixel, m_axis_tdata);
          err_cnt++;
        end
        if (m_axis_tlast != want.last) begin
          $error("is_last mismatch: expected %0d, actual %0d", want.last, m_axis_tlast);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int sent;
    int frame;
    int npix;
    int cut;
    bit brk;
    bit need_cfg;
    logic [IMG_W-1:0] wv;
    logic [IMG_W-1:0] hv;
    logic [7:0] pix;
    sent     = 0;
    frame    = 0;
    need_cfg = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (DIR_TAB[k]) begin
      if (DIR_TAB[k].kind == ROW_CFG) begin
        settle();
        write_reg(DIR_TAB[k].sel, DIR_TAB[k].val[IMG_W-1:0]);
      end else begin
        send_req(DIR_TAB[k].sel, DIR_TAB[k].val, DIR_TAB[k].typed, DIR_TAB[k].has,
                 {DIR_TAB[k].epix, DIR_TAB[k].elast});
      end
    end

    while (sent < 600 || frame < 12) begin
      // most frames get new sizes, some run back to back on the old ones
      if (need_cfg || frame < 3 || $urandom_range(3) != 0) begin
        case (frame)
          0: begin wv = 7'd127; hv = 7'd3; end
          1: begin wv = 7'd2; hv = 7'd64; end
          2: begin wv = 7'd64; hv = 7'd1; end
          default: begin
            wv = IMG_W'($urandom_range(1, 8));
            hv = IMG_W'($urandom_range(1, 8));
            if ($urandom_range(9) == 0) wv = IMG_W'($urandom_range(0, 127));
            else if ($urandom_range(9) == 0) hv = IMG_W'($urandom_range(0, 127));
          end
        endcase
        settle();
        if ($urandom_range(1) == 0) begin
          write_reg(REG_IMAGE_WIDTH, wv);
          write_reg(REG_IMAGE_HEIGHT, hv);
        end else begin
          write_reg(REG_IMAGE_HEIGHT, hv);
          write_reg(REG_IMAGE_WIDTH, wv);
        end
      end
      npix     = int'(dil_w) * int'(dil_h);
      brk      = (frame >= 3) && ($urandom_range(7) == 0);
      cut      = brk ? $urandom_range(0, npix - 1) : npix;
      need_cfg = brk;

      for (int i = 0; i < cut; i++) begin
        quiet = (sent >= 250 && sent < 400);
        if (frame == 3 && i == cut / 2) settle();
        if ($urandom_range(9) == 0) send_req(REQ_DRAIN, 8'($urandom), 1'b0, 1'b0, '0);
        case ($urandom_range(7))
          0: pix = 8'hff;
          1: pix = 8'h00;
          default: pix = 8'($urandom);
        endcase
        send_req(REQ_PIXEL, pix, 1'b0, 1'b0, '0);
        sent++;
      end
      if (!brk) begin
        if ($urandom_range(3) == 0) send_req(REQ_PIXEL, 8'($urandom), 1'b0, 1'b0, '0);
        while (dil_pend != 0) begin
          send_req(REQ_DRAIN, 8'($urandom), 1'b0, 1'b0, '0);
          sent++;
        end
        repeat ($urandom_range(0, 2)) send_req(REQ_DRAIN, 8'($urandom), 1'b0, 1'b0, '0);
      end
      frame++;
    end

    quiet = 1'b0;
    settle();
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
